// ===== rtl/pttbl_pkg.sv =====
// Shared types and constants for the presence tracker table.
package pttbl_pkg;

	// Command codes
	localparam logic [1:0] CMD_OBSERVE = 2'd0;
	localparam logic [1:0] CMD_TICK    = 2'd1;
	localparam logic [1:0] CMD_CONFIG  = 2'd2;
	localparam logic [1:0] CMD_REMOVE  = 2'd3;

	// Configuration register indexes
	localparam logic [2:0] REG_RSSI_THR = 3'd0;
	localparam logic [2:0] REG_WINDOW   = 3'd1;
	localparam logic [2:0] REG_MIN_CNT  = 3'd2;
	localparam logic [2:0] REG_TIMEOUT  = 3'd3;
	localparam logic [2:0] REG_STALE    = 3'd4;

	// Register values after reset
	localparam logic signed [7:0] RST_RSSI_THR = -8'sd70;
	localparam logic [31:0]       RST_WINDOW   = 32'd10000;
	localparam logic [7:0]        RST_MIN_CNT  = 8'd3;
	localparam logic [31:0]       RST_TIMEOUT  = 32'd60000;
	localparam logic [31:0]       RST_STALE    = 32'd86400000;

	// Result of the shared age compare
	typedef struct packed {
		logic ge;
		logic le;
	} age_res_t;

endpackage

// ===== rtl/pttbl_age_unit.sv =====
// Shared age unit: elapsed time modulo 2^32 compared against a limit.
module pttbl_age_unit (
	input  logic [31:0]         now,
	input  logic [31:0]         stamp,
	input  logic [31:0]         limit,
	output pttbl_pkg::age_res_t res
);
	import pttbl_pkg::*;

	logic [31:0] elapsed;

	// Take the wrapped difference and compare both ways
	always_comb begin
		elapsed = now - stamp;
		res.ge  = (elapsed >= limit);
		res.le  = (elapsed <= limit);
	end
endmodule

// ===== rtl/pttbl_ring_mem.sv =====
// Sighting time store: one write port, one registered read port.
module pttbl_ring_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [31:0]   rdata
);
	logic [31:0] mem [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/presence_tracker_table_top.sv =====
// Top level of the presence tracker table: sequencer, slot registers, ports.
// Each request is worked one at a time by a sequencer around one shared age
// comparator. Observe, config and remove take an address scan, one update step
// and one result step; an observe with seen low goes straight to the result.
// A tick walks the slots: an exit check per slot, plus an entry decision for each
// valid slot and a read and a count for each stored sighting of an absent slot,
// since the sighting store has one registered read port; a tick without unlock
// then runs the stale sweep over all slots. The input side is not ready while a
// request is in work; a finished result waits in the output register while the
// next request is taken. Configuration writes are accepted only while no request
// is in work.
module presence_tracker_table_top #(
	parameter int DEVICE_SLOTS   = 8,
	parameter int SIGHTING_DEPTH = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         command,
	input  logic [47:0]        device_address,
	input  logic               seen,
	input  logic [31:0]        time_ms,
	input  logic signed [7:0]  signal_strength,
	input  logic signed [7:0]  new_rssi_threshold,
	input  logic [31:0]        new_enter_window_ms,
	input  logic [7:0]         new_enter_min_count,
	input  logic [31:0]        new_presence_timeout_ms,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               unlock,
	output logic [5:0]         unlock_slot,
	output logic               no_free_slot,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	import pttbl_pkg::*;

	localparam int SW    = (DEVICE_SLOTS > 1) ? $clog2(DEVICE_SLOTS) : 1;
	localparam int IW    = (SIGHTING_DEPTH > 1) ? $clog2(SIGHTING_DEPTH) : 1;
	localparam int FW    = $clog2(SIGHTING_DEPTH + 1);
	localparam int DEPTH = DEVICE_SLOTS * SIGHTING_DEPTH;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef enum logic [3:0] {
		S_IDLE, S_FIND, S_ACT, S_TK_EXIT, S_TK_RD, S_TK_CNT, S_TK_DEC, S_STALE, S_DONE
	} state_t;

	state_t state_q;

	// Configuration registers
	logic signed [7:0] def_thr_q;
	logic [31:0]       def_win_q, def_to_q, stale_q;
	logic [7:0]        def_min_q;

	// Latched request
	logic [1:0]        cmd_q;
	logic [47:0]       addr_q;
	logic [31:0]       now_q, nwin_q, nto_q;
	logic signed [7:0] rssi_q, nthr_q;
	logic [7:0]        nmin_q;

	// Slot table
	logic                    valid_q   [DEVICE_SLOTS];
	logic [47:0]             saddr_q   [DEVICE_SLOTS];
	logic                    present_q [DEVICE_SLOTS];
	logic                    left_q    [DEVICE_SLOTS];
	logic [31:0]             last_q    [DEVICE_SLOTS];
	logic [31:0]             unlk_q    [DEVICE_SLOTS];
	logic [IW-1:0]           next_q    [DEVICE_SLOTS];
	logic [FW-1:0]           fill_q    [DEVICE_SLOTS];
	logic signed [7:0]       thr_q     [DEVICE_SLOTS];
	logic [31:0]             win_q     [DEVICE_SLOTS];
	logic [7:0]              min_q     [DEVICE_SLOTS];
	logic [31:0]             to_q      [DEVICE_SLOTS];

	// Sequencer registers
	logic [SW-1:0] k_q, hit_k_q, free_k_q;
	logic          hit_q, free_q;
	logic [IW-1:0] i_q;
	logic [FW-1:0] cnt_q;
	logic          res_unlock_q, res_nofree_q, out_valid_q;
	logic [5:0]    res_slot_q, out_slot_q;
	logic          out_unlock_q, out_nofree_q;

	// Shared unit and store
	logic [31:0] age_stamp, age_limit, rd_data;
	age_res_t    age;
	logic          mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;

	// Observe decode for the chosen slot
	logic [SW-1:0]     sk;
	logic              eff_present, pass;
	logic signed [7:0] eff_thr;
	logic [IW-1:0]     eff_p;
	logic              last_k, last_i, exit_hit, pres_now, enter_ok, pres_dec;

	assign in_ready     = (state_q == S_IDLE);
	assign cfg_ready    = (state_q == S_IDLE);
	assign out_valid    = out_valid_q;
	assign unlock       = out_unlock_q;
	assign unlock_slot  = out_slot_q;
	assign no_free_slot = out_nofree_q;

	// Select the operands of the age unit by sequencer step
	always_comb begin
		age_stamp = last_q[k_q];
		age_limit = to_q[k_q];
		case (state_q)
			S_TK_CNT: begin
				age_stamp = rd_data;
				age_limit = win_q[k_q];
			end
			S_STALE: begin
				age_limit = stale_q;
			end
			default: begin
			end
		endcase
	end

	pttbl_age_unit u_age (
		.now   (now_q),
		.stamp (age_stamp),
		.limit (age_limit),
		.res   (age)
	);

	// Decode the observe action and the tick decisions
	always_comb begin
		sk          = hit_q ? hit_k_q : free_k_q;
		eff_present = hit_q ? present_q[sk] : 1'b0;
		eff_thr     = hit_q ? thr_q[sk] : def_thr_q;
		eff_p       = hit_q ? next_q[sk] : '0;
		pass        = !((rssi_q != 8'sd0) && (rssi_q < eff_thr));
		mem_we      = (state_q == S_ACT) && (cmd_q == CMD_OBSERVE) &&
		              (hit_q || free_q) && !eff_present && pass;
		mem_waddr   = AW'(AW'(sk) * AW'(SIGHTING_DEPTH) + AW'(eff_p));
		mem_raddr   = AW'(AW'(k_q) * AW'(SIGHTING_DEPTH) + AW'(i_q));
		last_k      = (k_q == SW'(DEVICE_SLOTS - 1));
		last_i      = ((FW'(i_q) + FW'(1)) == fill_q[k_q]);
		exit_hit    = present_q[k_q] && (last_q[k_q] != 32'd0) && age.ge;
		pres_now    = present_q[k_q] && !exit_hit;
		enter_ok    = (8'(cnt_q) >= min_q[k_q]);
		pres_dec    = present_q[k_q] || enter_ok;
	end

	pttbl_ring_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (now_q),
		.raddr (mem_raddr),
		.rdata (rd_data)
	);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			def_thr_q <= RST_RSSI_THR;
			def_win_q <= RST_WINDOW;
			def_min_q <= RST_MIN_CNT;
			def_to_q  <= RST_TIMEOUT;
			stale_q   <= RST_STALE;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_RSSI_THR: def_thr_q <= cfg_data[7:0];
				REG_WINDOW:   def_win_q <= cfg_data;
				REG_MIN_CNT:  def_min_q <= cfg_data[7:0];
				REG_TIMEOUT:  def_to_q  <= cfg_data;
				REG_STALE:    stale_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Latch the accepted request
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q  <= command;
			addr_q <= device_address;
			now_q  <= time_ms;
			rssi_q <= signal_strength;
			nthr_q <= new_rssi_threshold;
			nwin_q <= new_enter_window_ms;
			nmin_q <= new_enter_min_count;
			nto_q  <= new_presence_timeout_ms;
		end
	end

	// Sequencer, slot table and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			k_q          <= '0;
			hit_k_q      <= '0;
			free_k_q     <= '0;
			hit_q        <= 1'b0;
			free_q       <= 1'b0;
			i_q          <= '0;
			cnt_q        <= '0;
			res_unlock_q <= 1'b0;
			res_nofree_q <= 1'b0;
			res_slot_q   <= '0;
			out_valid_q  <= 1'b0;
			out_unlock_q <= 1'b0;
			out_nofree_q <= 1'b0;
			out_slot_q   <= '0;
			for (int s = 0; s < DEVICE_SLOTS; s++) begin
				valid_q[s]   <= 1'b0;
				saddr_q[s]   <= '0;
				present_q[s] <= 1'b0;
				left_q[s]    <= 1'b0;
				last_q[s]    <= '0;
				unlk_q[s]    <= '0;
				next_q[s]    <= '0;
				fill_q[s]    <= '0;
				thr_q[s]     <= RST_RSSI_THR;
				win_q[s]     <= RST_WINDOW;
				min_q[s]     <= RST_MIN_CNT;
				to_q[s]      <= RST_TIMEOUT;
			end
		end else begin
			// Drop the result once taken, unless a new one replaces it
			if (out_valid_q && out_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						k_q          <= '0;
						hit_q        <= 1'b0;
						free_q       <= 1'b0;
						res_unlock_q <= 1'b0;
						res_nofree_q <= 1'b0;
						res_slot_q   <= '0;
						if (command == CMD_TICK) begin
							state_q <= S_TK_EXIT;
						end else if (command == CMD_OBSERVE && !seen) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_FIND;
						end
					end
				end
				S_FIND: begin
					// Scan for a match and the lowest free slot
					if (valid_q[k_q] && saddr_q[k_q] == addr_q && !hit_q) begin
						hit_q   <= 1'b1;
						hit_k_q <= k_q;
					end
					if (!valid_q[k_q] && !free_q) begin
						free_q   <= 1'b1;
						free_k_q <= k_q;
					end
					if (last_k) begin
						state_q <= S_ACT;
					end else begin
						k_q <= k_q + SW'(1);
					end
				end
				S_ACT: begin
					state_q <= S_DONE;
					if (cmd_q == CMD_REMOVE) begin
						if (hit_q) begin
							valid_q[sk]   <= 1'b0;
							saddr_q[sk]   <= '0;
							present_q[sk] <= 1'b0;
							left_q[sk]    <= 1'b0;
							last_q[sk]    <= '0;
							unlk_q[sk]    <= '0;
							next_q[sk]    <= '0;
							fill_q[sk]    <= '0;
							thr_q[sk]     <= def_thr_q;
							win_q[sk]     <= def_win_q;
							min_q[sk]     <= def_min_q;
							to_q[sk]      <= def_to_q;
						end
					end else if (!hit_q && !free_q) begin
						res_nofree_q <= 1'b1;
					end else begin
						// Claim a free slot, with default settings unless this is a config
						if (!hit_q) begin
							valid_q[sk]   <= 1'b1;
							saddr_q[sk]   <= addr_q;
							present_q[sk] <= 1'b0;
							left_q[sk]    <= 1'b0;
							unlk_q[sk]    <= '0;
							if (cmd_q == CMD_CONFIG || !pass) begin
								last_q[sk] <= '0;
								next_q[sk] <= '0;
								fill_q[sk] <= '0;
							end
							if (cmd_q != CMD_CONFIG) begin
								thr_q[sk] <= def_thr_q;
								win_q[sk] <= def_win_q;
								min_q[sk] <= def_min_q;
								to_q[sk]  <= def_to_q;
							end
						end
						if (cmd_q == CMD_CONFIG) begin
							thr_q[sk] <= nthr_q;
							win_q[sk] <= nwin_q;
							min_q[sk] <= nmin_q;
							to_q[sk]  <= nto_q;
						end else if (eff_present) begin
							last_q[sk] <= now_q;
						end else if (pass) begin
							// Record a sighting in the ring
							last_q[sk] <= now_q;
							next_q[sk] <= (eff_p == IW'(SIGHTING_DEPTH - 1)) ?
							              '0 : eff_p + IW'(1);
							if (!hit_q) begin
								fill_q[sk] <= FW'(1);
							end else if (fill_q[sk] != FW'(SIGHTING_DEPTH)) begin
								fill_q[sk] <= fill_q[sk] + FW'(1);
							end
						end
					end
				end
				S_TK_EXIT: begin
					if (!valid_q[k_q]) begin
						if (last_k) begin
							k_q     <= '0;
							state_q <= S_STALE;
						end else begin
							k_q <= k_q + SW'(1);
						end
					end else begin
						if (exit_hit) begin
							present_q[k_q] <= 1'b0;
							left_q[k_q]    <= 1'b1;
						end
						cnt_q <= '0;
						i_q   <= '0;
						if (!pres_now && fill_q[k_q] != '0) begin
							state_q <= S_TK_RD;
						end else begin
							state_q <= S_TK_DEC;
						end
					end
				end
				S_TK_RD: begin
					state_q <= S_TK_CNT;
				end
				S_TK_CNT: begin
					// Count sightings inside the window
					if (age.le) begin
						cnt_q <= cnt_q + FW'(1);
					end
					if (last_i) begin
						state_q <= S_TK_DEC;
					end else begin
						i_q     <= i_q + IW'(1);
						state_q <= S_TK_RD;
					end
				end
				S_TK_DEC: begin
					if (!present_q[k_q] && enter_ok) begin
						present_q[k_q] <= 1'b1;
					end
					if (pres_dec && (unlk_q[k_q] == 32'd0 || left_q[k_q])) begin
						unlk_q[k_q]  <= now_q;
						left_q[k_q]  <= 1'b0;
						res_unlock_q <= 1'b1;
						res_slot_q   <= 6'(k_q);
						state_q      <= S_DONE;
					end else if (last_k) begin
						k_q     <= '0;
						state_q <= S_STALE;
					end else begin
						k_q     <= k_q + SW'(1);
						state_q <= S_TK_EXIT;
					end
				end
				S_STALE: begin
					// Free absent slots not seen for too long
					if (valid_q[k_q] && !present_q[k_q] && age.ge) begin
						valid_q[k_q]   <= 1'b0;
						saddr_q[k_q]   <= '0;
						left_q[k_q]    <= 1'b0;
						last_q[k_q]    <= '0;
						unlk_q[k_q]    <= '0;
						next_q[k_q]    <= '0;
						fill_q[k_q]    <= '0;
						thr_q[k_q]     <= def_thr_q;
						win_q[k_q]     <= def_win_q;
						min_q[k_q]     <= def_min_q;
						to_q[k_q]      <= def_to_q;
					end
					if (last_k) begin
						state_q <= S_DONE;
					end else begin
						k_q <= k_q + SW'(1);
					end
				end
				S_DONE: begin
					// Hand the result over once the output register is free
					if (!out_valid_q || out_ready) begin
						out_valid_q  <= 1'b1;
						out_unlock_q <= res_unlock_q;
						out_slot_q   <= res_slot_q;
						out_nofree_q <= res_nofree_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

// ===== rtl/pttbl_checker.sv =====
// Port-level checks for the presence tracker table, bound to the top level.
module pttbl_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       unlock,
	input logic [5:0] unlock_slot,
	input logic       no_free_slot
);
	// An unlock result never reports a full table
	a_unlock_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && unlock |-> !no_free_slot)
		else $error("unlock and no_free_slot together");

	// Slot index is zero without an unlock
	a_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !unlock |-> unlock_slot == 6'd0)
		else $error("unlock_slot set without unlock");

	// Busy after taking a request
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready right after accept");

	// A stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(unlock_slot) &&
		$stable(unlock) && $stable(no_free_slot))
		else $error("result changed while stalled");
endmodule

bind presence_tracker_table_top pttbl_checker u_pttbl_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.unlock       (unlock),
	.unlock_slot  (unlock_slot),
	.no_free_slot (no_free_slot)
);

// ===== dv/presence_tracker_table_top_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the presence tracker table top level.
module presence_tracker_table_top_tb;
	import pttbl_pkg::*;

	localparam int SLOTS     = 8;
	localparam int DEPTH     = 8;
	localparam int LIMIT     = 1000000;
	localparam int SETTLE    = 250;
	localparam int POOL_SIZE = 11;

	typedef struct {
		logic [1:0]        cmd;
		logic [47:0]       addr;
		logic              seen;
		logic [31:0]       now;
		logic signed [7:0] rssi;
		logic signed [7:0] thr;
		logic [31:0]       win;
		logic [7:0]        minc;
		logic [31:0]       tmo;
	} request_t;

	typedef struct {
		logic       unl;
		logic [5:0] slot;
		logic       nofree;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] command = CMD_OBSERVE;
	logic [47:0] device_address = '0;
	logic seen = 1'b0;
	logic [31:0] time_ms = '0;
	logic signed [7:0] signal_strength = '0;
	logic signed [7:0] new_rssi_threshold = '0;
	logic [31:0] new_enter_window_ms = '0;
	logic [7:0] new_enter_min_count = '0;
	logic [31:0] new_presence_timeout_ms = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic unlock;
	logic [5:0] unlock_slot;
	logic no_free_slot;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	presence_tracker_table_top DUT (.*);

	// Generate clock
	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Tracker image: defaults and per-slot state
	logic signed [7:0] dflt_thr = RST_RSSI_THR;
	logic [31:0] dflt_win = RST_WINDOW;
	logic [7:0] dflt_min = RST_MIN_CNT;
	logic [31:0] dflt_tmo = RST_TIMEOUT;
	logic [31:0] stale_ms = RST_STALE;

	logic sl_valid [SLOTS];
	logic [47:0] sl_addr [SLOTS];
	logic sl_present [SLOTS];
	logic sl_left [SLOTS];
	logic [31:0] sl_seen [SLOTS];
	logic [31:0] sl_unlock [SLOTS];
	logic [31:0] sl_times [SLOTS][DEPTH];
	int sl_next [SLOTS];
	int sl_fill [SLOTS];
	logic signed [7:0] sl_thr [SLOTS];
	logic [31:0] sl_win [SLOTS];
	logic [7:0] sl_min [SLOTS];
	logic [31:0] sl_tmo [SLOTS];

	request_t pending_q [$];
	verdict_t verdict_q [$];
	request_t cur;
	int send_idle = 32;
	int recv_idle = 70;
	int errors = 0;
	int cycles = 0;
	logic [31:0] clock_ms = '0;
	logic [47:0] pool [POOL_SIZE];

	function automatic void free_slot(int k);
		sl_valid[k] = 1'b0;
		sl_addr[k] = '0;
		sl_present[k] = 1'b0;
		sl_left[k] = 1'b0;
		sl_seen[k] = '0;
		sl_unlock[k] = '0;
		sl_next[k] = 0;
		sl_fill[k] = 0;
		sl_thr[k] = dflt_thr;
		sl_win[k] = dflt_win;
		sl_min[k] = dflt_min;
		sl_tmo[k] = dflt_tmo;
	endfunction

	function automatic int lookup_slot(logic [47:0] a);
		for (int k = 0; k < SLOTS; k++)
			if (sl_valid[k] && sl_addr[k] == a)
				return k;
		return -1;
	endfunction

	function automatic int lookup_or_claim(logic [47:0] a);
		int k;
		k = lookup_slot(a);
		if (k >= 0)
			return k;
		for (k = 0; k < SLOTS; k++) begin
			if (!sl_valid[k]) begin
				free_slot(k);
				sl_addr[k] = a;
				sl_valid[k] = 1'b1;
				return k;
			end
		end
		return -1;
	endfunction

	function automatic int sightings_in_window(int k, logic [31:0] now);
		int n;
		logic [31:0] age;
		n = 0;
		for (int i = 0; i < sl_fill[k] && i < DEPTH; i++) begin
			age = now - sl_times[k][i];
			if (age <= sl_win[k])
				n++;
		end
		return n;
	endfunction

	// Apply one request to the tracker image and return its outcome
	function automatic verdict_t track_request(request_t r);
		verdict_t v;
		int k;
		int p;
		logic fired;
		logic [31:0] age;
		v = '{1'b0, 6'd0, 1'b0};
		case (r.cmd)
			CMD_OBSERVE: begin
				if (r.seen) begin
					k = lookup_or_claim(r.addr);
					if (k < 0) begin
						v.nofree = 1'b1;
					end else if (sl_present[k]) begin
						sl_seen[k] = r.now;
					end else if (!(r.rssi != 0 && r.rssi < sl_thr[k])) begin
						p = sl_next[k] % DEPTH;
						sl_seen[k] = r.now;
						sl_times[k][p] = r.now;
						sl_next[k] = (p + 1) % DEPTH;
						if (sl_fill[k] < DEPTH)
							sl_fill[k]++;
					end
				end
			end
			CMD_TICK: begin
				fired = 1'b0;
				for (k = 0; k < SLOTS && !fired; k++) begin
					if (sl_valid[k]) begin
						age = r.now - sl_seen[k];
						if (sl_present[k] && sl_seen[k] != 0 && age >= sl_tmo[k]) begin
							sl_present[k] = 1'b0;
							sl_left[k] = 1'b1;
						end
						if (!sl_present[k] && sightings_in_window(k, r.now) >= sl_min[k])
							sl_present[k] = 1'b1;
						if (sl_present[k] && (sl_unlock[k] == 0 || sl_left[k])) begin
							sl_unlock[k] = r.now;
							sl_left[k] = 1'b0;
							v.unl = 1'b1;
							v.slot = 6'(k);
							fired = 1'b1;
						end
					end
				end
				// sweep stale absent slots when nothing unlocked
				if (!fired) begin
					for (k = 0; k < SLOTS; k++) begin
						age = r.now - sl_seen[k];
						if (sl_valid[k] && !sl_present[k] && age >= stale_ms)
							free_slot(k);
					end
				end
			end
			CMD_CONFIG: begin
				k = lookup_or_claim(r.addr);
				if (k < 0) begin
					v.nofree = 1'b1;
				end else begin
					sl_thr[k] = r.thr;
					sl_win[k] = r.win;
					sl_min[k] = r.minc;
					sl_tmo[k] = r.tmo;
				end
			end
			default: begin
				k = lookup_slot(r.addr);
				if (k >= 0)
					free_slot(k);
			end
		endcase
		return v;
	endfunction

	function automatic void queue_request(logic [1:0] c, logic [47:0] a, logic s,
			logic [31:0] t, logic [7:0] rs, logic [7:0] th, logic [31:0] w,
			logic [7:0] m, logic [31:0] to);
		request_t r;
		r = '{c, a, s, t, rs, th, w, m, to};
		pending_q.push_back(r);
	endfunction

	function automatic logic [7:0] pick_rssi();
		int r;
		r = $urandom_range(99);
		if (r < 10)
			return 8'd0;
		if (r < 65)
			return 8'($urandom_range(0, 127) - 60);
		return 8'($urandom_range(255));
	endfunction

	// Build one random request, mostly plausible traffic on the address pool
	function automatic void queue_random();
		int r;
		logic [47:0] a;
		r = $urandom_range(99);
		a = ($urandom_range(19) == 0) ? {16'($urandom), 32'($urandom)}
			: pool[$urandom_range(POOL_SIZE - 1)];
		if (r < 5)
			clock_ms = $urandom;
		else if (r < 12)
			clock_ms += $urandom_range(300000);
		else
			clock_ms += $urandom_range(4000);
		r = $urandom_range(99);
		if (r < 48)
			queue_request(CMD_OBSERVE, a, $urandom_range(15) != 0, clock_ms, pick_rssi(),
				8'($urandom), $urandom, 8'($urandom), $urandom);
		else if (r < 78)
			queue_request(CMD_TICK, 48'($urandom), 1'($urandom), clock_ms, 8'($urandom),
				8'($urandom), $urandom, 8'($urandom), $urandom);
		else if (r < 90)
			queue_request(CMD_CONFIG, a, 1'($urandom), clock_ms, 8'($urandom),
				($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 80) - 90),
				($urandom_range(3) == 0) ? $urandom : $urandom_range(20000),
				8'($urandom_range(0, 5)),
				($urandom_range(3) == 0) ? $urandom : $urandom_range(60000));
		else
			queue_request(CMD_REMOVE, a, 1'($urandom), clock_ms, 8'($urandom),
				8'($urandom), $urandom, 8'($urandom), $urandom);
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [31:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_RSSI_THR: dflt_thr = data[7:0];
			REG_WINDOW:   dflt_win = data;
			REG_MIN_CNT:  dflt_min = data[7:0];
			REG_TIMEOUT:  dflt_tmo = data;
			default:      stale_ms = data;
		endcase
	endtask

	task automatic write_defaults(logic [7:0] th, logic [31:0] w, logic [7:0] m,
			logic [31:0] to, logic [31:0] st);
		write_reg(REG_RSSI_THR, {24'd0, th});
		write_reg(REG_WINDOW, w);
		write_reg(REG_MIN_CNT, {24'd0, m});
		write_reg(REG_TIMEOUT, to);
		write_reg(REG_STALE, st);
	endtask

	// Wait for every request to be taken and answered
	task automatic drain();
		while (pending_q.size() != 0 || in_valid || verdict_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Drive requests from the pending queue
	always @(posedge clk) begin
		if (arst_n && (!in_valid || in_ready)) begin
			if (in_valid)
				verdict_q.push_back(track_request(cur));
			if (pending_q.size() != 0 && $urandom_range(99) >= send_idle) begin
				cur = pending_q.pop_front();
				command <= cur.cmd;
				device_address <= cur.addr;
				seen <= cur.seen;
				time_ms <= cur.now;
				signal_strength <= cur.rssi;
				new_rssi_threshold <= cur.thr;
				new_enter_window_ms <= cur.win;
				new_enter_min_count <= cur.minc;
				new_presence_timeout_ms <= cur.tmo;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Check results against the oldest outcome waiting
	always @(posedge clk) begin
		verdict_t e;
		out_ready <= ($urandom_range(99) >= recv_idle);
		if (out_valid && out_ready) begin
			if (verdict_q.size() == 0) begin
				$error("unexpected result: unlock %0d slot %0d no_free_slot %0d",
					unlock, unlock_slot, no_free_slot);
				errors++;
			end else begin
				e = verdict_q.pop_front();
				if (unlock !== e.unl) begin
					$error("unlock: expected %0d, got %0d", e.unl, unlock);
					errors++;
				end
				if (unlock_slot !== e.slot) begin
					$error("unlock_slot: expected %0d, got %0d", e.slot, unlock_slot);
					errors++;
				end
				if (no_free_slot !== e.nofree) begin
					$error("no_free_slot: expected %0d, got %0d", e.nofree, no_free_slot);
					errors++;
				end
			end
		end
	end

	// Bound the run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("[presence_tracker_table_top] ERROR");
			$finish;
		end
	end

	initial begin
		for (int k = 0; k < SLOTS; k++) begin
			free_slot(k);
			for (int i = 0; i < DEPTH; i++)
				sl_times[k][i] = '0;
		end
		pool[0] = '0;
		pool[1] = '1;
		for (int i = 2; i < POOL_SIZE; i++)
			pool[i] = {16'($urandom), 32'($urandom)};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed: ignored observe, weak claim, zero minimum, unlock at time zero
		queue_request(CMD_OBSERVE, 48'd0, 1'b0, 32'd100, 8'd0, 0, 0, 0, 0);
		queue_request(CMD_OBSERVE, '1, 1'b1, 32'd100, 8'h80, 0, 0, 0, 0);
		queue_request(CMD_CONFIG, '1, 1'b0, 32'd100, 8'd0, 8'h80, '1, 8'd0, 32'd0);
		queue_request(CMD_TICK, 48'd0, 1'b0, 32'd0, 8'd0, 0, 0, 0, 0);
		queue_request(CMD_TICK, 48'd0, 1'b0, 32'd5, 8'd0, 0, 0, 0, 0);
		// sightings with strongest and missing signal, then entry
		queue_request(CMD_OBSERVE, 48'd0, 1'b1, 32'd200, 8'd127, 0, 0, 0, 0);
		queue_request(CMD_OBSERVE, 48'd0, 1'b1, 32'd300, 8'd127, 0, 0, 0, 0);
		queue_request(CMD_OBSERVE, 48'd0, 1'b1, 32'd400, 8'd0, 0, 0, 0, 0);
		queue_request(CMD_TICK, 48'd0, 1'b0, 32'd500, 8'd0, 0, 0, 0, 0);
		// present refresh, then exit and re-entry on a zero timeout
		queue_request(CMD_OBSERVE, '1, 1'b1, 32'd600, 8'd127, 0, 0, 0, 0);
		queue_request(CMD_TICK, 48'd0, 1'b0, 32'd700, 8'd0, 0, 0, 0, 0);
		// remove unknown and known
		queue_request(CMD_REMOVE, 48'h123456, 1'b0, 32'd800, 8'd0, 0, 0, 0, 0);
		queue_request(CMD_REMOVE, 48'd0, 1'b0, 32'd800, 8'd0, 0, 0, 0, 0);
		// fill the table, then overflow on observe and config
		for (int i = 1; i <= 7; i++)
			queue_request(CMD_OBSERVE, 48'(i), 1'b1, 32'd1000, 8'd127, 0, 0, 0, 0);
		queue_request(CMD_OBSERVE, 48'd8, 1'b1, 32'd1000, 8'd127, 0, 0, 0, 0);
		queue_request(CMD_CONFIG, 48'd9, 1'b0, 32'd1000, 8'd0, 8'h7F, '1, 8'hFF, '1);
		// ticks across the time wrap
		queue_request(CMD_TICK, 48'd0, 1'b0, 32'hFFFF_FFF0, 8'd0, 0, 0, 0, 0);
		queue_request(CMD_TICK, 48'd0, 1'b0, 32'h0000_0010, 8'd0, 0, 0, 0, 0);
		drain();

		// phase one: sender idles lightly, receiver heavily
		write_defaults(8'hC4, 32'd8000, 8'd2, 32'd20000, 32'd40000);
		for (int i = 0; i < 180; i++)
			queue_random();
		drain();

		// phase two: extremes, roles of idling swapped
		send_idle = 70;
		recv_idle = 32;
		write_defaults(8'h7F, '1, 8'd1, 32'd0, 32'd0);
		for (int i = 0; i < 180; i++)
			queue_random();
		drain();

		// phase three: no idling, opposite extremes
		send_idle = 0;
		recv_idle = 0;
		write_defaults(8'h80, 32'd5000, 8'hFF, '1, '1);
		for (int i = 0; i < 90; i++)
			queue_random();
		drain();
		write_defaults(8'hBA, 32'd0, 8'd0, 32'd3000, 32'd100000);
		for (int i = 0; i < 90; i++)
			queue_random();
		drain();

		if (errors == 0)
			$display("[presence_tracker_table_top] OK");
		else
			$display("[presence_tracker_table_top] ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/pttbl_pkg.sv
rtl/pttbl_age_unit.sv
rtl/pttbl_ring_mem.sv
rtl/presence_tracker_table_top.sv
rtl/pttbl_checker.sv
dv/presence_tracker_table_top_tb.sv
